// ===== rtl/scc_pkg.sv =====
// Shared types, constants and digit helpers for the seven-segment clock.
// No dependencies; every rtl file of the block imports this package.
package scc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_SHOW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  localparam logic [15:0] TPS_RESET          = 16'd1001;
  localparam logic [7:0]  SEG_POINT          = 8'h80;
  localparam logic [7:0]  SEG_BLANK          = 8'hFF;
  localparam logic [4:0]  HOUR_MAX           = 5'd23;
  localparam logic [5:0]  MINUTE_MAX         = 6'd59;
  localparam logic [5:0]  SECOND_MAX         = 6'd59;
  localparam logic [6:0]  SECONDS_PER_MINUTE = 7'd60;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
  };

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       day_odd;
    logic [4:0] thousands;
    logic [9:0] rest;
    logic       point;
  } item_t;

  typedef struct packed {
    logic [31:0] segs;
    logic        write;
    logic        led;
  } result_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } status_t;

  typedef struct packed {
    logic [4:0] quot;
    logic [9:0] rest;
  } split_k_t;

  typedef struct packed {
    logic [3:0] quot;
    logic [6:0] rest;
  } split_h_t;

  typedef struct packed {
    logic [3:0] hi;
    logic [3:0] lo;
  } pair_t;

  function automatic split_k_t split_1000(logic [13:0] v);
    split_k_t r;
    r.quot = '0;
    r.rest = v[9:0];
    for (int k = 1; k <= 16; k++) begin
      if (v >= 14'(k * 1000)) begin
        r.quot = 5'(k);
        r.rest = 10'(v - 14'(k * 1000));
      end
    end
    return r;
  endfunction

  function automatic split_h_t split_100(logic [9:0] v);
    split_h_t r;
    r.quot = '0;
    r.rest = v[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (v >= 10'(k * 100)) begin
        r.quot = 4'(k);
        r.rest = 7'(v - 10'(k * 100));
      end
    end
    return r;
  endfunction

  function automatic pair_t split_10(logic [6:0] v);
    pair_t r;
    r.hi = '0;
    r.lo = v[3:0];
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) begin
        r.hi = 4'(k);
        r.lo = 4'(v - 7'(k * 10));
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] seg_byte(logic [4:0] d, logic pt);
    logic [7:0] b;
    b = (d > 5'd9) ? SEG_BLANK : SEG_TABLE[d[3:0]];
    return pt ? b : (b | SEG_POINT);
  endfunction

endpackage

// ===== rtl/scc_in_reg.sv =====
// Input register of the seven-segment clock: unpacks the slave word and
// splits the show value into thousands and remainder. Uses scc_pkg.
module scc_in_reg import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [39:0] tdata_i,
  input  logic [1:0]  tuser_i,
  input  logic        advance_i,
  output logic        ready_o,
  output logic        valid_o,
  output item_t       item_o
);

  logic     valid_q;
  item_t    item_q;
  item_t    item_d;
  split_k_t split;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    split             = split_1000(tdata_i[31:18]);
    item_d.cmd        = cmd_e'(tuser_i);
    item_d.hour       = tdata_i[4:0];
    item_d.minute     = tdata_i[10:5];
    item_d.second     = tdata_i[16:11];
    item_d.day_odd    = tdata_i[17];
    item_d.thousands  = split.quot;
    item_d.rest       = split.rest;
    item_d.point      = tdata_i[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/scc_core.sv =====
// Clock state of the seven-segment clock: prescaler, seconds, hour, minute,
// day parity, LED and held segments, plus the next display. Uses scc_pkg.
module scc_core import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        step_i,
  input  item_t       item_i,
  output result_t     result_o,
  output status_t     status_o
);

  logic [15:0] tps_q;
  logic [15:0] tick_q, tick_d;
  logic [5:0]  sec_q, sec_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic        odd_q, odd_d;
  logic        led_q, led_d;
  logic [31:0] segs_q, segs_d;
  logic [16:0] tick_inc;
  logic [6:0]  sec_inc;
  logic        show_time;
  logic        show_num;
  pair_t       hour_p;
  pair_t       min_p;
  split_h_t    num_h;
  pair_t       num_p;

  always_comb begin
    tick_d    = tick_q;
    sec_d     = sec_q;
    hour_d    = hour_q;
    min_d     = min_q;
    odd_d     = odd_q;
    led_d     = led_q;
    show_time = 1'b0;
    show_num  = 1'b0;
    tick_inc  = {1'b0, tick_q} + 17'd1;
    sec_inc   = {1'b0, sec_q} + 7'd1;

    unique case (item_i.cmd)
      CMD_TICK: begin
        if (tick_inc >= {1'b0, tps_q}) begin
          tick_d = '0;
          led_d  = sec_q[0];
          if (sec_inc >= SECONDS_PER_MINUTE) begin
            sec_d = '0;
            if (min_q >= MINUTE_MAX) begin
              min_d  = '0;
              hour_d = (hour_q >= HOUR_MAX) ? '0 : hour_q + 5'd1;
            end else begin
              min_d = min_q + 6'd1;
            end
            show_time = 1'b1;
          end else begin
            sec_d = sec_inc[5:0];
          end
        end else begin
          tick_d = tick_inc[15:0];
        end
      end
      CMD_SET: begin
        hour_d    = (item_i.hour > HOUR_MAX) ? HOUR_MAX : item_i.hour;
        min_d     = (item_i.minute > MINUTE_MAX) ? MINUTE_MAX : item_i.minute;
        sec_d     = (item_i.second > SECOND_MAX) ? SECOND_MAX : item_i.second;
        odd_d     = item_i.day_odd;
        tick_d    = '0;
        show_time = 1'b1;
      end
      CMD_SHOW: begin
        show_num = 1'b1;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase

    hour_p = split_10({2'b00, hour_d});
    min_p  = split_10({1'b0, min_d});
    num_h  = split_100(item_i.rest);
    num_p  = split_10(num_h.rest);

    if (show_time) begin
      segs_d = {seg_byte({1'b0, min_p.lo}, !odd_d),
                seg_byte({1'b0, min_p.hi}, 1'b0),
                seg_byte({1'b0, hour_p.lo}, 1'b0),
                seg_byte({1'b0, hour_p.hi}, 1'b0)};
    end else if (show_num) begin
      segs_d = {seg_byte({1'b0, num_p.lo}, item_i.point),
                seg_byte({1'b0, num_p.hi}, 1'b0),
                seg_byte({1'b0, num_h.quot}, 1'b0),
                seg_byte(item_i.thousands, 1'b0)};
    end else begin
      segs_d = segs_q;
    end
  end

  assign result_o.segs  = segs_d;
  assign result_o.write = show_time || show_num;
  assign result_o.led   = led_d;

  assign status_o.hour   = hour_q;
  assign status_o.minute = min_q;
  assign status_o.second = sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      sec_q  <= '0;
      hour_q <= '0;
      min_q  <= '0;
      odd_q  <= 1'b0;
      led_q  <= 1'b0;
      segs_q <= '1;
    end else if (step_i) begin
      tick_q <= tick_d;
      sec_q  <= sec_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      odd_q  <= odd_d;
      led_q  <= led_d;
      segs_q <= segs_d;
    end
  end

endmodule

// ===== rtl/seven_segment_clock.sv =====
// Seven-segment HHMM clock. Each slave word (tick, set time, show number or
// unused) gives exactly one master word: the four active-low segment bytes
// now held, a display-write flag and the LED level. A word passes an input
// register and a result register; one word is accepted in every cycle as
// long as the master side takes its words, and the clock state updates as a
// word moves between them. The user must write ticks_per_second through
// cfg_we_i/cfg_wdata_i only while no word is in flight; the block does not enforce it.
// Depends on scc_pkg, scc_in_reg and scc_core.
module seven_segment_clock import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // set_hour[4:0], set_minute[10:5], set_second[16:11], set_day_odd[17],
  // shown_number[31:18], show_point[32], zero[39:33]
  input  logic [39:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seg_thousands[7:0], seg_hundreds[15:8], seg_tens[23:16],
  // seg_units[31:24], led_level_out[32], zero[39:33]
  output logic [39:0] m_axis_tdata,
  // display_write[0]
  output logic [0:0]  m_axis_tuser
);

  logic    in_valid;
  item_t   item;
  logic    advance;
  result_t result;
  status_t status;
  logic    out_valid_q;
  result_t out_q;

  assign advance = in_valid && (!out_valid_q || m_axis_tready);

  scc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .tdata_i   (s_axis_tdata),
    .tuser_i   (s_axis_tuser),
    .advance_i (advance),
    .ready_o   (s_axis_tready),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  scc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (item),
    .result_o    (result),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.led, out_q.segs};
  assign m_axis_tuser  = out_q.write;

`ifndef SYNTH
  a_time_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.hour <= HOUR_MAX && status.minute <= MINUTE_MAX &&
    status.second <= SECOND_MAX)
    else $error("clock state out of range");

  a_set_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item.cmd == CMD_SET |=> m_axis_tvalid && m_axis_tuser[0])
    else $error("set time word did not rewrite the display");

  a_unused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item.cmd == CMD_NONE |=> m_axis_tvalid && !m_axis_tuser[0])
    else $error("unused command rewrote the display");
`endif

endmodule
